### rtl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and codes of the sorted key/value table: command and status
// codes, field widths and the per-cycle operation that the cell row receives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXISTS   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd4;

   // Operation broadcast to every cell in the update cycle
   typedef struct packed {
      logic               ins;        // open a slot at the lower bound, fill it
      logic               rem;        // close the slot of the matching entry
      logic               upd;        // overwrite the value of the matching entry
      logic [KEY_W-1:0]   new_key;
      logic [VALUE_W-1:0] new_value;
   } skvt_op_type;

endpackage

`default_nettype wire

### rtl/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted table: holds a key and a value, compares its key
// with the broadcast key and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
   import skvt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               cmp_en,
   input  wire logic               in_use,
   input  wire logic [KEY_W-1:0]   cmp_key,
   input  skvt_op_type             op,
   input  wire logic               prev_lt,
   input  wire logic [KEY_W-1:0]   prev_key,
   input  wire logic [VALUE_W-1:0] prev_value,
   input  wire logic [KEY_W-1:0]   next_key,
   input  wire logic [VALUE_W-1:0] next_value,
   output logic [KEY_W-1:0]        cell_key,
   output logic [VALUE_W-1:0]      cell_value,
   output logic                    cell_lt,
   output logic                    cell_eq,
   output logic [VALUE_W-1:0]      sel_value
);

   logic [KEY_W-1:0]   key_ff,   key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               lt_ff,    lt_in;
   logic               eq_ff,    eq_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (cmp_en) begin
         lt_in = in_use && (key_ff < cmp_key);
         eq_in = in_use && (key_ff == cmp_key);
      end
      // Cells at or above the lower bound move up; the one at the lower bound takes
      // the new entry.
      if (op.ins && !lt_ff) begin
         if (prev_lt) begin
            key_in   = op.new_key;
            value_in = op.new_value;
         end else begin
            key_in   = prev_key;
            value_in = prev_value;
         end
      end
      if (op.rem && !lt_ff) begin
         key_in   = next_key;
         value_in = next_value;
      end
      if (op.upd && eq_ff) begin
         value_in = op.new_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;
   assign cell_lt    = lt_ff;
   assign cell_eq    = eq_ff;
   assign sel_value  = eq_ff ? value_ff : '0;

endmodule

`default_nettype wire

### rtl/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Ordered key/value table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): cmd, 64-bit key and 32-bit value.
//   Commands are add, set, get and remove. Each transfer yields exactly one
//   response transfer (rsp_valid / rsp_stall) with status, result value and
//   the entry count after the operation.
//   Timing: a request is taken in the idle cycle, while every cell compares
//   its key with the request key; in the execute state the flags pick the hit
//   and the lower bound, the row shifts by one slot for insert or remove, and
//   the response is loaded into the output register. A new request is not
//   taken until the update of the last one is done.
//   The compare and the shift of the cell row do not depend on CAPACITY.
//   A waiting response does not block the next request: its compare cycle
//   runs while rsp_stall is high. Its update then holds until the output
//   register drains.
//   Reset empties the table (entry count zero) and drops any pending response;
//   the cell contents are not cleared, only slots below the count are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_core
   import skvt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [VALUE_W-1:0]  req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_result_value,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   value_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff,    status_in;
   logic [VALUE_W-1:0]   result_ff,    result_in;
   logic [COUNT_W-1:0]   entry_ff,     entry_in;

   logic                 accept;
   logic                 go;
   logic                 hit;
   logic                 full;
   logic [VALUE_W-1:0]   hit_value;
   skvt_op_type          op;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   logic [KEY_W-1:0]     cell_key   [CAPACITY];
   logic [VALUE_W-1:0]   cell_value [CAPACITY];
   logic [VALUE_W-1:0]   sel_value  [CAPACITY];
   logic                 cell_lt    [CAPACITY];
   logic                 cell_eq    [CAPACITY];

   // Take a request only in idle; the compare runs on the same edge.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // Advance the update only when the output register can take the response.
   assign go        = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   // Match flags are one-hot at most, since keys are unique.
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit       = hit | cell_eq[i];
         hit_value = hit_value | sel_value[i];
      end
   end

   // Decide the table operation and the response.
   always_comb begin
      op.ins       = 1'b0;
      op.rem       = 1'b0;
      op.upd       = 1'b0;
      op.new_key   = key_ff;
      op.new_value = value_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      count_in     = count_ff;
      case (cmd_ff)
         CMD_ADD, CMD_SET: begin
            if (hit) begin
               if (cmd_ff == CMD_ADD) begin
                  status_in = STATUS_EXISTS;
                  result_in = '0;
               end else begin
                  status_in = STATUS_REPLACED;
                  result_in = hit_value;
                  op.upd    = go;
               end
            end else if (full) begin
               status_in = STATUS_FULL;
               result_in = '0;
            end else begin
               status_in = STATUS_OK;
               result_in = '0;
               op.ins    = go;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_GET: begin
            if (hit) begin
               status_in = STATUS_OK;
               result_in = hit_value;
            end else begin
               status_in = STATUS_NOTFOUND;
               result_in = '0;
            end
         end
         default: begin
            if (hit) begin
               status_in = STATUS_OK;
               result_in = hit_value;
               op.rem    = go;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOTFOUND;
               result_in = '0;
            end
         end
      endcase
      if (!go) begin
         status_in = status_ff;
         result_in = result_ff;
         count_in  = count_ff;
      end
   end

   // Report the count masked to the response field width.
   assign count_wide = {{COUNT_W{1'b0}}, count_in};
   assign entry_in   = go ? count_wide[COUNT_W-1:0] : entry_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request fields for the update cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      status_ff <= status_in;
      result_ff <= result_in;
      entry_ff  <= entry_in;
   end

   // Cell row: slot 0 holds the smallest key.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               prev_lt;
      logic [KEY_W-1:0]   prev_key;
      logic [VALUE_W-1:0] prev_value;
      logic [KEY_W-1:0]   next_key;
      logic [VALUE_W-1:0] next_value;
      logic               in_use;

      assign in_use = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign prev_key   = key_ff;
         assign prev_value = value_ff;
      end else begin : g_mid
         assign prev_lt    = cell_lt[i-1];
         assign prev_key   = cell_key[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_key   = cell_key[i];
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_key   = cell_key[i+1];
         assign next_value = cell_value[i+1];
      end

      skvt_cell u_cell (
         .clock      (clock),
         .cmp_en     (accept),
         .in_use     (in_use),
         .cmp_key    (req_key),
         .op         (op),
         .prev_lt    (prev_lt),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .next_key   (next_key),
         .next_value (next_value),
         .cell_key   (cell_key[i]),
         .cell_value (cell_value[i]),
         .cell_lt    (cell_lt[i]),
         .cell_eq    (cell_eq[i]),
         .sel_value  (sel_value[i])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = result_ff;
   assign rsp_entry_count  = entry_ff;

endmodule

`default_nettype wire

### dv/sorted_key_value_table_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core_tb
// Checks every response of the ordered key/value table against a shadow copy
// of the table held in the bench. A driver sends add, set, get and remove
// requests from a queue with random gaps, and a monitor compares each
// response field by field while the response side stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_value_table_core_tb;
   import skvt_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int POOL_SIZE    = 96;    // more keys than slots, so fill phases hit full
   localparam int RANDOM_ITEMS = 1200;
   localparam int MAX_GAP      = 15;
   localparam int TAIL_CYCLES  = 20;

   // Stimulus phases: each one leans on the command mix differently
   typedef enum {FILL_UP, MIXED, DRAIN_DOWN, NOISE_ONLY} phase_kind_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      int unsigned        gap;          // idle cycles before this request
      bit                 drain_first;  // hold until every response is back
   } table_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
   } table_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = CMD_GET;
   logic [KEY_W-1:0]    req_key = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_result_value;
   logic [COUNT_W-1:0]  rsp_entry_count;

   sorted_key_value_table_core #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // Shadow table: keys ascending, no gaps, fill_level valid entries
   logic [KEY_W-1:0]   shadow_key [TABLE_DEPTH];
   logic [VALUE_W-1:0] shadow_val [TABLE_DEPTH];
   int                 fill_level = 0;

   table_req_type pending_q [$];        // requests not yet presented
   table_rsp_type predicted_rsp_q [$];  // responses owed by the block
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int          mismatches = 0;
   bit          req_taken = 1'b0;       // request transfer at the last rising edge
   bit          rsp_taken = 1'b0;       // response transfer at the last rising edge
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned rsp_count = 0;
   bit          rsp_calm = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor: apply one request to the shadow table, return its response
   // ------------------------------------------------------------------------
   function automatic table_rsp_type apply_table_op(input table_req_type op);
      table_rsp_type r;
      int            pos;
      bit            hit;
      r.status = STATUS_OK;
      r.value  = '0;
      // lower bound: first entry whose key is not below the request key
      pos = 0;
      while (pos < fill_level && shadow_key[pos] < op.key) pos++;
      hit = (pos < fill_level) && (shadow_key[pos] == op.key);
      case (op.cmd)
         CMD_ADD, CMD_SET: begin
            // an existing key wins over a full table
            if (hit) begin
               if (op.cmd == CMD_ADD) begin
                  r.status = STATUS_EXISTS;
               end else begin
                  r.value         = shadow_val[pos];
                  shadow_val[pos] = op.value;
                  r.status        = STATUS_REPLACED;
               end
            end else if (fill_level >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // open a slot at the lower bound
               for (int i = fill_level; i > pos; i--) begin
                  shadow_key[i] = shadow_key[i-1];
                  shadow_val[i] = shadow_val[i-1];
               end
               shadow_key[pos] = op.key;
               shadow_val[pos] = op.value;
               fill_level++;
            end
         end
         CMD_GET: begin
            if (hit) r.value = shadow_val[pos];
            else r.status = STATUS_NOTFOUND;
         end
         default: begin
            if (hit) begin
               r.value = shadow_val[pos];
               // close the slot
               for (int i = pos; i + 1 < fill_level; i++) begin
                  shadow_key[i] = shadow_key[i+1];
                  shadow_val[i] = shadow_val[i+1];
               end
               fill_level--;
            end else begin
               r.status = STATUS_NOTFOUND;
            end
         end
      endcase
      r.count = COUNT_W'(fill_level);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input bit drain_first,
                           input bit calm);
      table_req_type item;
      item.cmd         = cmd;
      item.key         = key;
      item.value       = value;
      item.gap         = calm ? 0 : $urandom_range(0, MAX_GAP);
      item.drain_first = drain_first;
      pending_q.push_back(item);
   endtask

   function automatic logic [CMD_W-1:0] pick_cmd(input phase_kind_type kind);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         FILL_UP:
            return roll < 40 ? CMD_ADD : roll < 75 ? CMD_SET : roll < 90 ? CMD_GET : CMD_REMOVE;
         DRAIN_DOWN:
            return roll < 10 ? CMD_ADD : roll < 20 ? CMD_SET : roll < 40 ? CMD_GET : CMD_REMOVE;
         default:
            return roll < 25 ? CMD_ADD : roll < 50 ? CMD_SET : roll < 75 ? CMD_GET : CMD_REMOVE;
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input phase_kind_type kind);
      // fresh keys mostly miss; scale them so small and large magnitudes show up
      if (kind == NOISE_ONLY || $urandom_range(0, 9) == 0)
         return {$urandom(), $urandom()} >> $urandom_range(0, KEY_W - 1);
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 15))
         0:       v = 32'h0000_0001;
         1:       v = '1;
         default: v = $urandom();
      endcase
      return (v == '0) ? 32'h0000_0001 : v;
   endfunction

   // ------------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed corner cases, then phased random traffic
   // ------------------------------------------------------------------------
   initial begin
      int             produced;
      int             phase_idx;
      int             phase_len;
      phase_kind_type kind;
      bit             calm;

      // Key pool: extremes, the sign boundary, and adjacent pairs
      key_pool[0] = '0;
      key_pool[1] = 64'd1;
      key_pool[2] = 64'd2;
      key_pool[3] = '1;
      key_pool[4] = 64'hFFFF_FFFF_FFFF_FFFE;
      key_pool[5] = 64'h7FFF_FFFF_FFFF_FFFF;
      key_pool[6] = 64'h8000_0000_0000_0000;
      key_pool[7] = 64'h8000_0000_0000_0001;
      key_pool[8] = 64'h0000_0000_FFFF_FFFF;
      key_pool[9] = 64'h0000_0001_0000_0000;
      for (int i = 10; i < POOL_SIZE; i += 2) begin
         key_pool[i]   = {$urandom(), $urandom()} >> $urandom_range(0, KEY_W - 1);
         key_pool[i+1] = key_pool[i] + 64'd1;
      end

      // Directed part: empty-table misses, both key extremes, duplicate add,
      // replace, the unsigned sign boundary, a miss between stored keys, and
      // removes at the front, middle and back of the row
      push_req(CMD_GET,    64'd0,                   32'h1,         1'b0, 1'b0);
      push_req(CMD_REMOVE, '1,                      32'h1,         1'b0, 1'b0);
      push_req(CMD_ADD,    64'd0,                   32'h0000_0001, 1'b0, 1'b1);
      push_req(CMD_ADD,    '1,                      32'hFFFF_FFFF, 1'b0, 1'b1);
      push_req(CMD_ADD,    64'd0,                   32'h1234_5678, 1'b0, 1'b0);
      push_req(CMD_SET,    64'd0,                   32'h0000_0005, 1'b0, 1'b0);
      push_req(CMD_SET,    64'h8000_0000_0000_0000, 32'hA5A5_A5A5, 1'b0, 1'b1);
      push_req(CMD_ADD,    64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
      push_req(CMD_GET,    64'h8000_0000_0000_0000, 32'h1,         1'b0, 1'b1);
      push_req(CMD_GET,    64'h7FFF_FFFF_FFFF_FFFF, 32'h1,         1'b0, 1'b0);
      push_req(CMD_GET,    '1,                      32'h1,         1'b0, 1'b0);
      push_req(CMD_GET,    64'd1,                   32'h1,         1'b0, 1'b0);
      push_req(CMD_REMOVE, 64'h8000_0000_0000_0000, 32'h5A5A_5A5A, 1'b1, 1'b0);
      push_req(CMD_GET,    64'h8000_0000_0000_0000, 32'h1,         1'b0, 1'b1);
      push_req(CMD_REMOVE, 64'd0,                   32'h1,         1'b0, 1'b0);
      push_req(CMD_REMOVE, '1,                      32'h1,         1'b0, 1'b1);
      push_req(CMD_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1,         1'b0, 1'b0);
      push_req(CMD_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1,         1'b0, 1'b0);

      // Random part: fill to capacity, churn, drain, then noise; the first
      // request of each phase waits for the table to go quiet
      produced  = 0;
      phase_idx = 0;
      while (produced < RANDOM_ITEMS) begin
         kind      = (phase_idx < 4) ? phase_kind_type'(phase_idx)
                                     : phase_kind_type'($urandom_range(0, 3));
         calm      = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(60, 180);
         for (int n = 0; n < phase_len; n++)
            push_req(pick_cmd(kind), pick_key(kind), pick_value(), n == 0, calm);
         produced += phase_len;
         phase_idx++;
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // drain everything, then leave a quiet tail to catch stray responses
      while (pending_q.size() > 0 || req_valid) @(posedge clock);
      while (predicted_rsp_q.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Rising edge: sample both channels. Check the response first, then
   // predict the request taken on the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      table_req_type op;
      table_rsp_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (predicted_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: response expected none actual status %0d value %h count %0d",
                        $time, rsp_status, rsp_result_value, rsp_entry_count);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_result_value !== want.value) begin
                  mismatches++;
                  $display("%0t: result_value expected %h actual %h",
                           $time, want.value, rsp_result_value);
               end
               if (rsp_entry_count !== want.count) begin
                  mismatches++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.count, rsp_entry_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            op.cmd    = req_cmd;
            op.key    = req_key;
            op.value  = req_value;
            predicted_rsp_q.push_back(apply_table_op(op));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: hold a stalled transfer, otherwise count down the gap
   // and present the next request. Valid is written once per edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      table_req_type next_req;
      logic          next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         // a transfer just finished: load the gap of the request behind it
         if (req_valid) gap_left = (pending_q.size() > 0) ? pending_q[0].gap : 0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_q.size() > 0 &&
                      !(pending_q[0].drain_first && predicted_rsp_q.size() > 0)) begin
            next_req   = pending_q.pop_front();
            req_cmd   <= next_req.cmd;
            req_key   <= next_req.key;
            req_value <= next_req.value;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Response stall: after each transfer draw a new stall length; choose anew
   // between stalling and calm stretches every 64 responses
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_count++;
         if (rsp_count % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= !reset && (stall_left > 0);
   end

endmodule

### sorted_key_value_table_core.f
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table_core.sv
dv/sorted_key_value_table_core_tb.sv
